// ===== rtl/swm_pkg.sv =====
package swm_pkg;

  localparam int MAX_DIM       = 4096;
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN      = 24;
  localparam int CORDIC_RUN    = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

  localparam int PIXW  = 12;
  localparam int IDXW  = $clog2(MAX_DIM);
  localparam int MAGW  = (IDXW + 4 > 16) ? IDXW + 4 : 16;
  localparam int INVW  = 24;
  localparam int CENW  = 16;
  localparam int TW    = MAGW + INVW - 6;
  localparam int TLW   = (TW + 1) / 2;
  localparam int THW   = TW - TLW;
  localparam int ZW    = 34;
  localparam int XW    = 34;
  localparam int RW    = 32;
  localparam int ENTW  = 21;
  localparam int MATW  = 63;
  localparam int PW    = ENTW + RW;
  localparam int NW    = PW + 2;
  localparam int DW    = NW - 1;
  localparam int AW    = NW + 8;
  localparam int QW    = 24;
  localparam int CMPW  = DW + QW;
  localparam int OUTW  = 24;
  localparam int QDEPTH = 8;
  localparam int QAW   = $clog2(QDEPTH);
  localparam int CFGIW = 3;

  localparam logic [31:0] INV_TWO_PI = 32'h28BE_60DB;
  localparam logic signed [XW-1:0] CORDIC_GAIN  = XW'(32'h26DD_3B6A);
  localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(32'h4000_0000);
  localparam logic signed [ZW-1:0] HALF_TURN    = ZW'(32'h8000_0000);

  localparam logic [OUTW-1:0] OUT_MAX = 24'h7F_FFFF;
  localparam logic [OUTW-1:0] OUT_MIN = 24'h80_0000;

  localparam logic [INVW-1:0] INV_FOCAL_RST = 24'h40_0000;
  localparam logic [MATW-1:0] MAT_ROW0_RST  = 63'h0040_0000_0000_0000;
  localparam logic [MATW-1:0] MAT_ROW1_RST  = 63'h0000_0002_0000_0000;
  localparam logic [MATW-1:0] MAT_ROW2_RST  = 63'h0000_0000_0000_1000;

  typedef enum logic [CFGIW-1:0] {
    REG_INV_FOCAL_X = 3'd0,
    REG_INV_FOCAL_Y = 3'd1,
    REG_CENTER_X    = 3'd2,
    REG_CENTER_Y    = 3'd3,
    REG_MAT_ROW0    = 3'd4,
    REG_MAT_ROW1    = 3'd5,
    REG_MAT_ROW2    = 3'd6
  } swm_reg_t;

  typedef struct packed {
    logic signed [ZW-1:0] z;
    logic                 flip;
  } swm_angle_t;

  typedef struct packed {
    swm_angle_t ax;
    swm_angle_t ay;
  } swm_pair_t;

  // arctan(2^-i) in turns, Q0.32
  function automatic logic signed [ZW-1:0] atan_turn(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h2000_0000;
      1:  v = 32'h12E4_051E;
      2:  v = 32'h09FB_385B;
      3:  v = 32'h0511_11D4;
      4:  v = 32'h028B_0D43;
      5:  v = 32'h0145_D7E1;
      6:  v = 32'h00A2_F61E;
      7:  v = 32'h0051_7C55;
      8:  v = 32'h0028_BE53;
      9:  v = 32'h0014_5F2F;
      10: v = 32'h000A_2F98;
      11: v = 32'h0005_17CC;
      12: v = 32'h0002_8BE6;
      13: v = 32'h0001_45F3;
      14: v = 32'h0000_A2FA;
      15: v = 32'h0000_517D;
      16: v = 32'h0000_28BE;
      17: v = 32'h0000_145F;
      18: v = 32'h0000_0A30;
      19: v = 32'h0000_0518;
      20: v = 32'h0000_028C;
      21: v = 32'h0000_0146;
      22: v = 32'h0000_00A3;
      23: v = 32'h0000_0051;
      default: v = 32'h0;
    endcase
    return ZW'(v);
  endfunction

endpackage

// ===== rtl/spherical_warp_map_top.sv =====
// channel  direction  handshake          payload
// in       request    in_valid/in_stall  in_pix_row, in_pix_col
// out      result     out_valid/out_stall out_src_x, out_src_y, out_bad_point
// cfg      write      cfg_valid/cfg_ready cfg_index, cfg_data
//
// one pixel per clock sustained while in_stall and out_stall stay low; a pixel
// passes the angle set-up registers, the queue, then the CORDIC rotation
// stages, the ray and matrix registers and the divider set-up, quotient bits and saturation
// in_stall rises once 8 requests sit between the input and the back pipe
// out_stall freezes the whole back pipe while out_valid is high; the front keeps filling the queue
// synchronous active-low reset clears control and loads the default registers
module spherical_warp_map_top import swm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [PIXW-1:0]  in_pix_row,
  input  logic [PIXW-1:0]  in_pix_col,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUTW-1:0]  out_src_x,
  output logic [OUTW-1:0]  out_src_y,
  output logic             out_bad_point,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFGIW-1:0] cfg_index,
  input  logic [MATW-1:0]  cfg_data
);

  logic [INVW-1:0] inv_focal_x_r, inv_focal_y_r;
  logic [CENW-1:0] center_x_r, center_y_r;
  logic [MATW-1:0] mat_row0_r, mat_row1_r, mat_row2_r;

  logic      push, pop, q_empty;
  swm_pair_t push_data, q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_focal_x_r <= INV_FOCAL_RST;
      inv_focal_y_r <= INV_FOCAL_RST;
      center_x_r    <= '0;
      center_y_r    <= '0;
      mat_row0_r    <= MAT_ROW0_RST;
      mat_row1_r    <= MAT_ROW1_RST;
      mat_row2_r    <= MAT_ROW2_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (swm_reg_t'(cfg_index))
        REG_INV_FOCAL_X: inv_focal_x_r <= cfg_data[INVW-1:0];
        REG_INV_FOCAL_Y: inv_focal_y_r <= cfg_data[INVW-1:0];
        REG_CENTER_X:    center_x_r    <= cfg_data[CENW-1:0];
        REG_CENTER_Y:    center_y_r    <= cfg_data[CENW-1:0];
        REG_MAT_ROW0:    mat_row0_r    <= cfg_data;
        REG_MAT_ROW1:    mat_row1_r    <= cfg_data;
        REG_MAT_ROW2:    mat_row2_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  swm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_pix_row  (in_pix_row),
    .in_pix_col  (in_pix_col),
    .inv_focal_x (inv_focal_x_r),
    .inv_focal_y (inv_focal_y_r),
    .center_x    (center_x_r),
    .center_y    (center_y_r),
    .pop         (pop),
    .push        (push),
    .push_data   (push_data)
  );

  swm_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (push_data),
    .pop   (pop),
    .dout  (q_data),
    .empty (q_empty)
  );

  swm_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_data        (q_data),
    .pop           (pop),
    .mat_row0      (mat_row0_r),
    .mat_row1      (mat_row1_r),
    .mat_row2      (mat_row2_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_src_x     (out_src_x),
    .out_src_y     (out_src_y),
    .out_bad_point (out_bad_point)
  );

endmodule

// ===== rtl/swm_front.sv =====
module swm_front import swm_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [PIXW-1:0] in_pix_row,
  input  logic [PIXW-1:0] in_pix_col,
  input  logic [INVW-1:0] inv_focal_x,
  input  logic [INVW-1:0] inv_focal_y,
  input  logic [CENW-1:0] center_x,
  input  logic [CENW-1:0] center_y,
  input  logic            pop,
  output logic            push,
  output swm_pair_t       push_data
);

  function automatic logic [IDXW-1:0] clamp_idx(input logic [PIXW-1:0] p);
    logic [31:0] v;
    v = 32'(p);
    if (v >= 32'(MAX_DIM)) v = 32'(MAX_DIM - 1);
    return IDXW'(v);
  endfunction

  logic           accept;
  logic [QAW:0]   occ_r, occ_nxt;
  logic [3:0]     v_r;

  logic [MAGW-1:0]   mag_r [2];
  logic [MAGW-1:0]   mag_nxt [2];
  logic              neg1_r [2];
  logic              neg1_nxt [2];
  logic [TW-1:0]     t_r [2];
  logic [TW-1:0]     t_nxt [2];
  logic              neg2_r [2];
  logic [TLW+31:0]   plo_r [2];
  logic [TLW+31:0]   plo_nxt [2];
  logic [THW+31:0]   phi_r [2];
  logic [THW+31:0]   phi_nxt [2];
  logic              neg3_r [2];
  swm_pair_t         ang_r, ang_nxt;

  logic [PIXW-1:0]      pix [2];
  logic [CENW-1:0]      cen [2];
  logic [INVW-1:0]      inv [2];
  logic [MAGW:0]        diff [2];
  logic [MAGW+INVW-1:0] prod [2];
  logic [TW+31:0]       full [2];
  logic [31:0]          phase [2];
  logic signed [ZW-1:0] zs [2];
  logic signed [ZW-1:0] z [2];
  logic                 flip [2];

  // credit covers items in flight here and items sitting in the queue
  assign in_stall = (occ_r >= (QAW+1)'(QDEPTH));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    occ_nxt = occ_r;
    if (accept && !pop) occ_nxt = occ_r + 1'b1;
    else if (!accept && pop) occ_nxt = occ_r - 1'b1;
  end

  always_comb begin
    pix[0] = in_pix_col;
    pix[1] = in_pix_row;
    cen[0] = center_x;
    cen[1] = center_y;
    inv[0] = inv_focal_x;
    inv[1] = inv_focal_y;
    for (int k = 0; k < 2; k++) begin
      diff[k] = (MAGW+1)'({clamp_idx(pix[k]), 4'b0000}) - (MAGW+1)'(cen[k]);
      neg1_nxt[k] = diff[k][MAGW];
      mag_nxt[k]  = diff[k][MAGW] ? MAGW'(-diff[k]) : MAGW'(diff[k]);

      prod[k]  = (MAGW+INVW)'(mag_r[k]) * (MAGW+INVW)'(inv[k]);
      t_nxt[k] = prod[k][MAGW+INVW-1:6];

      // split the turn scaling into two narrow partial products
      plo_nxt[k] = (TLW+32)'(t_r[k][TLW-1:0]) * (TLW+32)'(INV_TWO_PI);
      phi_nxt[k] = (THW+32)'(t_r[k][TW-1:TLW]) * (THW+32)'(INV_TWO_PI);

      full[k]  = (TW+32)'({phi_r[k], {TLW{1'b0}}}) + (TW+32)'(plo_r[k]);
      phase[k] = full[k][51:20];
      if (neg3_r[k]) phase[k] = -phase[k];
      zs[k]   = ZW'(signed'(phase[k]));
      z[k]    = zs[k];
      flip[k] = 1'b0;
      if (zs[k] > QUARTER_TURN) begin
        z[k]    = zs[k] - HALF_TURN;
        flip[k] = 1'b1;
      end else if (zs[k] < -QUARTER_TURN) begin
        z[k]    = zs[k] + HALF_TURN;
        flip[k] = 1'b1;
      end
    end
    ang_nxt.ax.z    = z[0];
    ang_nxt.ax.flip = flip[0];
    ang_nxt.ay.z    = z[1];
    ang_nxt.ay.flip = flip[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      v_r   <= '0;
    end else begin
      occ_r <= occ_nxt;
      v_r   <= {v_r[2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      mag_r[k]  <= mag_nxt[k];
      neg1_r[k] <= neg1_nxt[k];
      t_r[k]    <= t_nxt[k];
      neg2_r[k] <= neg1_r[k];
      plo_r[k]  <= plo_nxt[k];
      phi_r[k]  <= phi_nxt[k];
      neg3_r[k] <= neg2_r[k];
    end
    ang_r <= ang_nxt;
  end

  assign push      = v_r[3];
  assign push_data = ang_r;

endmodule

// ===== rtl/swm_fifo.sv =====
module swm_fifo import swm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  swm_pair_t din,
  input  logic      pop,
  output swm_pair_t dout,
  output logic      empty
);

  swm_pair_t      slot_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] rp_r, rp_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign dout  = slot_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= din;
  end

endmodule

// ===== rtl/swm_cordic.sv =====
module swm_cordic import swm_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  swm_angle_t           ang,
  output logic signed [XW-1:0] sine,
  output logic signed [XW-1:0] cosine
);

  logic signed [XW-1:0] x_r [CORDIC_RUN+1];
  logic signed [XW-1:0] y_r [CORDIC_RUN+1];
  logic signed [ZW-1:0] z_r [CORDIC_RUN+1];
  logic                 f_r [CORDIC_RUN+1];
  logic signed [XW-1:0] x_nxt [CORDIC_RUN+1];
  logic signed [XW-1:0] y_nxt [CORDIC_RUN+1];
  logic signed [ZW-1:0] z_nxt [CORDIC_RUN+1];
  logic                 f_nxt [CORDIC_RUN+1];

  always_comb begin
    x_nxt[0] = CORDIC_GAIN;
    y_nxt[0] = '0;
    z_nxt[0] = ang.z;
    f_nxt[0] = ang.flip;
    for (int i = 0; i < CORDIC_RUN; i++) begin
      if (!z_r[i][ZW-1]) begin
        x_nxt[i+1] = x_r[i] - (y_r[i] >>> i);
        y_nxt[i+1] = y_r[i] + (x_r[i] >>> i);
        z_nxt[i+1] = z_r[i] - atan_turn(i);
      end else begin
        x_nxt[i+1] = x_r[i] + (y_r[i] >>> i);
        y_nxt[i+1] = y_r[i] - (x_r[i] >>> i);
        z_nxt[i+1] = z_r[i] + atan_turn(i);
      end
      f_nxt[i+1] = f_r[i];
      // undo the half-turn fold on the last rotation
      if (i == CORDIC_RUN - 1 && f_r[i]) begin
        x_nxt[i+1] = -x_nxt[i+1];
        y_nxt[i+1] = -y_nxt[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i <= CORDIC_RUN; i++) begin
        x_r[i] <= x_nxt[i];
        y_r[i] <= y_nxt[i];
        z_r[i] <= z_nxt[i];
        f_r[i] <= f_nxt[i];
      end
    end
  end

  assign sine   = y_r[CORDIC_RUN];
  assign cosine = x_r[CORDIC_RUN];

endmodule

// ===== rtl/swm_back.sv =====
module swm_back import swm_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  swm_pair_t       q_data,
  output logic            pop,
  input  logic [MATW-1:0] mat_row0,
  input  logic [MATW-1:0] mat_row1,
  input  logic [MATW-1:0] mat_row2,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [OUTW-1:0] out_src_x,
  output logic [OUTW-1:0] out_src_y,
  output logic            out_bad_point
);

  localparam int BLAT = CORDIC_RUN + 1 + 4 + QW + 1;

  function automatic logic signed [ENTW-1:0] mat_ent(input logic [MATW-1:0] row,
                                                     input int pos);
    return row[pos*ENTW +: ENTW];
  endfunction

  logic            adv;
  logic [BLAT-1:0] v_r;

  logic signed [XW-1:0] sx, cx, sy, cy;

  logic signed [RW-1:0] r_r [3];
  logic signed [RW-1:0] r_nxt [3];
  logic signed [PW-1:0] p_r [3][3];
  logic signed [PW-1:0] p_nxt [3][3];
  logic signed [NW-1:0] n_r [3];
  logic signed [NW-1:0] n_nxt [3];

  // index 0 is the set-up stage, index j+1 the j-th quotient bit
  logic [AW-1:0]  rem_r [2][QW+1];
  logic [AW-1:0]  rem_nxt [2][QW+1];
  logic [QW-1:0]  q_r [2][QW+1];
  logic [QW-1:0]  q_nxt [2][QW+1];
  logic           sgn_r [2][QW+1];
  logic           sgn_nxt [2][QW+1];
  logic           ovf_r [2][QW+1];
  logic           ovf_nxt [2][QW+1];
  logic [DW-1:0]  d_r [QW+1];
  logic [DW-1:0]  d_nxt [QW+1];
  logic           dbad_r [QW+1];
  logic           dbad_nxt [QW+1];

  logic [OUTW-1:0] src_x_r, src_y_r;
  logic [OUTW-1:0] res [2];
  logic            bad_r, bad_nxt;

  logic signed [RW-1:0]   s0, c0, s1, c1;
  logic signed [2*RW-1:0] m0, m2;
  logic [NW-1:0]          mg [2];
  logic [CMPW-1:0]        trial;
  logic                   ge;

  assign adv = !v_r[BLAT-1] || !out_stall;
  assign pop = adv && !q_empty;

  swm_cordic u_cordic_x (
    .clk    (clk),
    .en     (adv),
    .ang    (q_data.ax),
    .sine   (sx),
    .cosine (cx)
  );

  swm_cordic u_cordic_y (
    .clk    (clk),
    .en     (adv),
    .ang    (q_data.ay),
    .sine   (sy),
    .cosine (cy)
  );

  // ray and projection
  always_comb begin
    s0 = RW'(sx);
    c0 = RW'(cx);
    s1 = RW'(sy);
    c1 = RW'(cy);
    m0 = (2*RW)'(s0) * (2*RW)'(c1);
    m2 = (2*RW)'(c0) * (2*RW)'(c1);
    r_nxt[0] = m0[RW+29:30];
    r_nxt[1] = s1;
    r_nxt[2] = m2[RW+29:30];
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 3; c++) begin
        case (k)
          0:       p_nxt[k][c] = PW'(mat_ent(mat_row0, 2 - c)) * PW'(r_r[c]);
          1:       p_nxt[k][c] = PW'(mat_ent(mat_row1, 2 - c)) * PW'(r_r[c]);
          default: p_nxt[k][c] = PW'(mat_ent(mat_row2, 2 - c)) * PW'(r_r[c]);
        endcase
      end
      n_nxt[k] = NW'(p_r[k][0]) + NW'(p_r[k][1]) + NW'(p_r[k][2]);
    end
  end

  // restoring divide on magnitudes, one quotient bit per stage
  always_comb begin
    d_nxt[0]    = n_r[2][DW-1:0];
    dbad_nxt[0] = n_r[2][NW-1] || (n_r[2] == '0);
    for (int l = 0; l < 2; l++) begin
      sgn_nxt[l][0] = n_r[l][NW-1];
      mg[l] = n_r[l][NW-1] ? NW'(-n_r[l]) : NW'(n_r[l]);
      rem_nxt[l][0] = {mg[l], 8'b0};
      ovf_nxt[l][0] = CMPW'({mg[l], 8'b0}) >= {n_r[2][DW-1:0], {QW{1'b0}}};
      q_nxt[l][0]   = '0;
    end
    trial = '0;
    ge    = 1'b0;
    for (int j = 0; j < QW; j++) begin
      d_nxt[j+1]    = d_r[j];
      dbad_nxt[j+1] = dbad_r[j];
      for (int l = 0; l < 2; l++) begin
        trial = CMPW'(d_r[j]) << (QW - 1 - j);
        ge    = CMPW'(rem_r[l][j]) >= trial;
        rem_nxt[l][j+1] = ge ? rem_r[l][j] - trial[AW-1:0] : rem_r[l][j];
        q_nxt[l][j+1]   = {q_r[l][j][QW-2:0], ge};
        sgn_nxt[l][j+1] = sgn_r[l][j];
        ovf_nxt[l][j+1] = ovf_r[l][j];
      end
    end
  end

  // sign and saturation
  always_comb begin
    bad_nxt = dbad_r[QW];
    for (int l = 0; l < 2; l++) begin
      res[l] = '0;
      if (!dbad_r[QW]) begin
        if (ovf_r[l][QW]) begin
          res[l]  = sgn_r[l][QW] ? OUT_MIN : OUT_MAX;
          bad_nxt = 1'b1;
        end else if (sgn_r[l][QW] && q_r[l][QW] > OUT_MIN) begin
          res[l]  = OUT_MIN;
          bad_nxt = 1'b1;
        end else if (!sgn_r[l][QW] && q_r[l][QW] > OUT_MAX) begin
          res[l]  = OUT_MAX;
          bad_nxt = 1'b1;
        end else begin
          res[l] = sgn_r[l][QW] ? -q_r[l][QW] : q_r[l][QW];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[BLAT-2:0], pop};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        r_r[k] <= r_nxt[k];
        n_r[k] <= n_nxt[k];
        for (int c = 0; c < 3; c++) p_r[k][c] <= p_nxt[k][c];
      end
      for (int j = 0; j <= QW; j++) begin
        d_r[j]    <= d_nxt[j];
        dbad_r[j] <= dbad_nxt[j];
        for (int l = 0; l < 2; l++) begin
          rem_r[l][j] <= rem_nxt[l][j];
          q_r[l][j]   <= q_nxt[l][j];
          sgn_r[l][j] <= sgn_nxt[l][j];
          ovf_r[l][j] <= ovf_nxt[l][j];
        end
      end
      src_x_r <= res[0];
      src_y_r <= res[1];
      bad_r   <= bad_nxt;
    end
  end

  assign out_valid     = v_r[BLAT-1];
  assign out_src_x     = src_x_r;
  assign out_src_y     = src_y_r;
  assign out_bad_point = bad_r;

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  import swm_pkg::*;

  localparam logic [CFGIW-1:0] REG_SPARE = 3'd7;

  typedef struct {
    logic [OUTW-1:0] x;
    logic [OUTW-1:0] y;
    logic            bad;
  } warp_point_t;

  class warp_board;
    logic [INVW-1:0] inv_fx, inv_fy;
    logic [CENW-1:0] cen_x, cen_y;
    logic [MATW-1:0] mat [3];
    warp_point_t     pending_pts [$];
    int              errors;

    static const longint atan_q32 [24] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
      'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
      'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051};

    function new();
      inv_fx = INV_FOCAL_RST;
      inv_fy = INV_FOCAL_RST;
      cen_x  = '0;
      cen_y  = '0;
      mat[0] = MAT_ROW0_RST;
      mat[1] = MAT_ROW1_RST;
      mat[2] = MAT_ROW2_RST;
      errors = 0;
    endfunction

    function void set_reg(logic [CFGIW-1:0] idx, logic [MATW-1:0] data);
      case (idx)
        REG_INV_FOCAL_X: inv_fx = data[INVW-1:0];
        REG_INV_FOCAL_Y: inv_fy = data[INVW-1:0];
        REG_CENTER_X:    cen_x  = data[CENW-1:0];
        REG_CENTER_Y:    cen_y  = data[CENW-1:0];
        REG_MAT_ROW0:    mat[0] = data;
        REG_MAT_ROW1:    mat[1] = data;
        REG_MAT_ROW2:    mat[2] = data;
        default: ;
      endcase
    endfunction

    function void angle_sincos(longint unsigned idx, longint unsigned cen,
                               longint unsigned inv, output longint s,
                               output longint c);
      longint          diff, z, x, y, xs, ys;
      longint unsigned mag, t;
      logic [31:0]     ph;
      bit              flip;
      diff = longint'(idx << 4) - longint'(cen);
      mag  = (diff < 0) ? -diff : diff;
      t    = ((mag * inv) >> 6) * 64'h28BE60DB;
      ph   = t[51:20];
      if (diff < 0) ph = 32'd0 - ph;
      z    = longint'($signed(ph));
      flip = 0;
      // fold into the half turn the rotation can reach
      if (z > 64'sh40000000) begin
        z -= 64'sh80000000;
        flip = 1;
      end else if (z < -64'sh40000000) begin
        z += 64'sh80000000;
        flip = 1;
      end
      x = 64'sh26DD3B6A;
      y = 0;
      for (int i = 0; i < CORDIC_RUN; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= atan_q32[i];
        end else begin
          x += ys; y -= xs; z += atan_q32[i];
        end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
    endfunction

    function longint quot_sat(longint num, longint den, inout bit bad);
      longint q;
      q = (num * 256) / den;
      if (q > 64'sd8388607) begin
        bad = 1;
        return 64'sd8388607;
      end
      if (q < -64'sd8388608) begin
        bad = 1;
        return -64'sd8388608;
      end
      return q;
    endfunction

    function void note(logic [PIXW-1:0] row, logic [PIXW-1:0] col);
      longint unsigned r, cl;
      longint          sx, cx, sy, cy, ray [3], n [3], qx, qy;
      bit              bad;
      warp_point_t     p;
      r  = row;
      cl = col;
      if (r >= MAX_DIM) r = MAX_DIM - 1;
      if (cl >= MAX_DIM) cl = MAX_DIM - 1;
      angle_sincos(cl, cen_x, inv_fx, sx, cx);
      angle_sincos(r, cen_y, inv_fy, sy, cy);
      ray[0] = (sx * cy) >>> 30;
      ray[1] = sy;
      ray[2] = (cx * cy) >>> 30;
      for (int k = 0; k < 3; k++)
        n[k] = longint'($signed(mat[k][62:42])) * ray[0]
             + longint'($signed(mat[k][41:21])) * ray[1]
             + longint'($signed(mat[k][20:0])) * ray[2];
      bad = 0;
      qx  = 0;
      qy  = 0;
      if (n[2] <= 0) bad = 1;
      else begin
        qx = quot_sat(n[0], n[2], bad);
        qy = quot_sat(n[1], n[2], bad);
      end
      p.x   = qx[OUTW-1:0];
      p.y   = qy[OUTW-1:0];
      p.bad = bad;
      pending_pts.push_back(p);
    endfunction

    function void check(logic [OUTW-1:0] x, logic [OUTW-1:0] y, logic bad);
      warp_point_t p;
      if (pending_pts.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result x=%h y=%h bad=%b", x, y, bad);
        return;
      end
      p = pending_pts.pop_front();
      if (x !== p.x || y !== p.y || bad !== p.bad) begin
        errors++;
        if (errors <= 10)
          $display("got x=%h y=%h bad=%b, want x=%h y=%h bad=%b",
                   x, y, bad, p.x, p.y, p.bad);
      end
    endfunction
  endclass

  logic             clk = 0;
  logic             rst_n = 0;
  logic             in_valid = 0;
  logic             in_stall;
  logic [PIXW-1:0]  in_pix_row = '0;
  logic [PIXW-1:0]  in_pix_col = '0;
  logic             out_valid;
  logic             out_stall = 0;
  logic [OUTW-1:0]  out_src_x, out_src_y;
  logic             out_bad_point;
  logic             cfg_valid = 0;
  logic             cfg_ready;
  logic [CFGIW-1:0] cfg_index = '0;
  logic [MATW-1:0]  cfg_data = '0;

  warp_board board = new();
  bit noisy = 1;
  bit long_hold_req = 0;
  int hold_left = 0;
  int idle_left = 0;

  spherical_warp_map_top dut (.*);

  initial forever #6 clk = ~clk;

  initial begin
    #(12 * 600000);
    $display("spherical_warp_map_top: mismatch");
    $finish;
  end

  // receiver: checks results and drives its own stall pattern
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) board.check(out_src_x, out_src_y, out_bad_point);
      if (long_hold_req) begin
        long_hold_req = 0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1;
      end else if (idle_left > 0) begin
        idle_left--;
        out_stall <= 1;
      end else if (noisy && $urandom_range(0, 4) == 0) begin
        idle_left = $urandom_range(0, 16);
        out_stall <= 1;
      end else
        out_stall <= 0;
    end
  end

  task automatic cfg_write(logic [CFGIW-1:0] idx, logic [MATW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, data);
    cfg_valid <= 0;
  endtask

  task automatic send_pix(logic [PIXW-1:0] row, logic [PIXW-1:0] col);
    if (noisy && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid   <= 1;
    in_pix_row <= row;
    in_pix_col <= col;
    do @(posedge clk); while (in_stall);
    board.note(row, col);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending_pts.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic load_all(logic [INVW-1:0] ifx, logic [INVW-1:0] ify,
                          logic [CENW-1:0] ccx, logic [CENW-1:0] ccy,
                          logic [MATW-1:0] m0, logic [MATW-1:0] m1,
                          logic [MATW-1:0] m2, bit junk);
    // junk sets bits above the register width, which must be dropped
    cfg_write(REG_INV_FOCAL_X, junk ? MATW'({$urandom, $urandom, ifx}) : MATW'(ifx));
    cfg_write(REG_INV_FOCAL_Y, junk ? MATW'({$urandom, $urandom, ify}) : MATW'(ify));
    cfg_write(REG_CENTER_X, junk ? MATW'({$urandom, $urandom, ccx}) : MATW'(ccx));
    cfg_write(REG_CENTER_Y, junk ? MATW'({$urandom, $urandom, ccy}) : MATW'(ccy));
    cfg_write(REG_MAT_ROW0, m0);
    cfg_write(REG_MAT_ROW1, m1);
    cfg_write(REG_MAT_ROW2, m2);
  endtask

  function automatic logic [MATW-1:0] mrow(int e2, int e1, int e0);
    logic [ENTW-1:0] a, b, c;
    a = e2[ENTW-1:0];
    b = e1[ENTW-1:0];
    c = e0[ENTW-1:0];
    return {a, b, c};
  endfunction

  function automatic logic [PIXW-1:0] pick_pix(logic [CENW-1:0] cen);
    int p;
    if ($urandom_range(0, 3) == 0) return PIXW'($urandom);
    p = int'(cen >> 4) + $urandom_range(0, 1024) - 512;
    if (p < 0) p = 0;
    if (p > 4095) p = 4095;
    return PIXW'(p);
  endfunction

  function automatic int rnd_ent();
    return $urandom_range(0, 2097151) - 1048576;
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // defaults after reset, spare index must leave everything alone
    cfg_write(REG_SPARE, MATW'({$urandom, $urandom}));
    send_pix(0, 0);
    send_pix(4095, 4095);
    send_pix(0, 4095);
    send_pix(4095, 0);
    send_pix(12'hAAA, 12'h555);
    send_pix(12'h555, 12'hAAA);
    send_pix(1, 2);
    repeat (130) send_pix(PIXW'($urandom), PIXW'($urandom));
    drain();

    for (int ph = 1; ph < 8; ph++) begin
      logic [CENW-1:0] ccx, ccy;
      case (ph)
        1: begin
          ccx = CENW'(640 * 16);
          ccy = CENW'(360 * 16);
          load_all(4194, 4194, ccx, ccy, mrow(512000, 0, 327680),
                   mrow(0, 512000, 184320), mrow(0, 0, 512), 0);
          send_pix(360, 640);
          send_pix(0, 0);
          send_pix(4095, 4095);
        end
        2: begin
          ccx = 16'hFFFF;
          ccy = 16'hFFFF;
          load_all(24'hFFFFFF, 24'hFFFFFF, ccx, ccy,
                   mrow(1048575, -1048576, 1048575), mrow(-1048576, 1048575, -1048576),
                   mrow(1048575, 1048575, 1048575), 0);
          send_pix(4095, 4095);
          send_pix(0, 0);
        end
        3: begin
          ccx = 0;
          ccy = 0;
          // zero angles with a zero third row: denominator never positive
          load_all(0, 0, ccx, ccy, mrow(4096, 0, 0), mrow(0, 4096, 0),
                   mrow(0, 0, 0), 0);
          send_pix(0, 0);
          send_pix(4095, 4095);
          drain();
          cfg_write(REG_MAT_ROW2, mrow(0, 0, -4096));
          send_pix(7, 9);
          drain();
          // tiny denominator forces saturation
          cfg_write(REG_MAT_ROW2, mrow(0, 0, 1));
          cfg_write(REG_MAT_ROW0, mrow(0, 0, 1048575));
          cfg_write(REG_MAT_ROW1, mrow(0, 0, -1048576));
          send_pix(3, 3);
        end
        default: begin
          ccx = CENW'($urandom);
          ccy = CENW'($urandom);
          load_all(INVW'($urandom_range(1000, 60000)), INVW'($urandom_range(1000, 60000)),
                   ccx, ccy,
                   mrow(rnd_ent(), rnd_ent() >>> 4, rnd_ent()),
                   mrow(rnd_ent() >>> 4, rnd_ent(), rnd_ent()),
                   mrow(rnd_ent() >>> 6, rnd_ent() >>> 6,
                        $urandom_range(65536, 1048575)), 1);
        end
      endcase
      if (ph == 7) noisy = 0;
      for (int i = 0; i < 145; i++) begin
        if (ph == 4 && i == 10) long_hold_req = 1;
        if (ph == 5 && i == 60) begin
          in_valid <= 0;
          while (board.pending_pts.size() != 0) @(posedge clk);
        end
        send_pix(pick_pix(ccy), pick_pix(ccx));
      end
      drain();
    end

    if (board.errors == 0) $display("spherical_warp_map_top: match");
    else $display("spherical_warp_map_top: mismatch");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/swm_pkg.sv
rtl/swm_front.sv
rtl/swm_fifo.sv
rtl/swm_cordic.sv
rtl/swm_back.sv
rtl/spherical_warp_map_top.sv
tb/sv/tb.sv
